@@ hw/rtl/iktg_pkg.sv @@
// Package for the iambic keyer tone gate: widths, codes, reset values, sine table function.
`default_nettype none

package iktg_pkg;

    // Default sizes of the sine table and of the phase fraction
    localparam int unsigned TABLE_SIZE_DEF      = 256;
    localparam int unsigned PHASE_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned DIT_W      = 15;
    localparam int unsigned STEP_W     = 23;
    localparam int unsigned TICKS_W    = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 23;

    // Configuration reset values
    localparam logic             STRAIGHT_MODE_RST = 1'b0;
    localparam logic [DIT_W-1:0]  DIT_SAMPLES_RST  = 15'd900;
    localparam logic [STEP_W-1:0] TONE_STEP_RST    = 23'd782937;

    // Sine table generation constants (pi in Q62, full scale)
    localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C234;
    localparam logic [63:0] AMPLITUDE    = 64'd32767;
    localparam int unsigned SERIES_TERMS = 40;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRAIGHT_MODE = 2'd0,
        CFG_DIT_SAMPLES   = 2'd1,
        CFG_TONE_STEP     = 2'd2
    } cfg_reg_t;

    // Keyer phases
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_DIT       = 3'd1,
        PH_DAH       = 3'd2,
        PH_SPACE     = 3'd3,
        PH_SPACE_DAH = 3'd4,
        PH_SPACE_DIT = 3'd5
    } keyer_phase_t;

    // floor(a*b / 2^62), product assumed below 2^126
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Unsigned floor(num / den) by shift and subtract, elaboration only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          bi;
        rem = '0;
        quo = '0;
        for (bi = 63; bi >= 0; bi--)
        begin
            rem = {rem[63:0], num[bi]};
            if (rem >= {1'b0, den})
            begin
                rem     = rem - {1'b0, den};
                quo[bi] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One sine table entry, full scale 32767, truncated toward zero.
    // Elaboration only: evaluated through a Taylor series in Q62.
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned i,
                                                              input int unsigned tbl_bits);
        int unsigned half;
        int unsigned quarter;
        int unsigned idx;
        int unsigned j;
        int unsigned k;
        logic        neg;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] v;
        logic [63:0] dvs;
        logic signed [SAMPLE_W-1:0] mag;
        half    = 1 << (tbl_bits - 1);
        quarter = 1 << (tbl_bits - 2);
        neg     = 1'b0;
        idx     = i;
        v       = 64'd0;
        if (idx >= half)
        begin
            neg = 1'b1;
            idx = idx - half;
        end
        j = (idx <= quarter) ? idx : half - idx;
        if (j == 0)
        begin
            v = 64'd0;
        end
        else if (j == quarter)
        begin
            v = AMPLITUDE;
        end
        else
        begin
            x    = (PI_Q62 >> (tbl_bits - 1)) * 64'(j);
            x2   = mul_q62(x, x);
            term = x;
            sum  = x;
            for (k = 1; k < SERIES_TERMS; k++)
            begin
                dvs  = 64'((2 * k) * (2 * k + 1));
                term = div_u64(mul_q62(term, x2), dvs);
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            a = (sum >> 31) * AMPLITUDE;
            b = ({33'd0, sum[30:0]} * AMPLITUDE) >> 31;
            v = (a + b) >> 31;
        end
        mag = $signed(v[SAMPLE_W-1:0]);
        return neg ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/iktg_if.sv @@
// Channel interfaces of the keyer tone gate: paddle input, audio output, config writes.
`default_nettype none

// Paddle levels, one transfer per sample tick
interface iktg_key_if;
    logic valid;
    logic ready;
    logic dit_paddle;
    logic dah_paddle;

    modport source (output valid, output dit_paddle, output dah_paddle, input ready);
    modport sink   (input valid, input dit_paddle, input dah_paddle, output ready);
endinterface

// Audio result, one transfer per sample tick
interface iktg_audio_if import iktg_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] audio_sample;
    logic                       tone_on;

    modport source (output valid, output audio_sample, output tone_on, input ready);
    modport sink   (input valid, input audio_sample, input tone_on, output ready);
endinterface

// Configuration register writes
interface iktg_cfg_if import iktg_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/iambic_keyer_tone_gate_top.sv @@
// Iambic keyer with sine tone gate: keyer state machine, phase accumulator, sine ROM.
// A taken paddle transfer loads the ROM read register, and the output register takes the
// result when it is free. Throughput: one tick per cycle while the output is not stalled;
// the registered sine ROM read and the output register form a two-stage pipeline, and
// the keyer state updates in the cycle of the transfer.
// Reset (rst_n low, asynchronous): keyer idle, tone off, tick count and phase zero,
// pipeline empty, config back to its defaults. The ROM is constant and needs no clearing.
`default_nettype none

module iambic_keyer_tone_gate_top import iktg_pkg::*; #(
    parameter int unsigned TABLE_SIZE      = TABLE_SIZE_DEF,
    parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    iktg_cfg_if.sink      cfg,
    iktg_key_if.sink      keys,
    iktg_audio_if.source  audio
);

    localparam int unsigned TABLE_BITS = $clog2(TABLE_SIZE);
    localparam int unsigned ACC_W      = TABLE_BITS + PHASE_FRAC_BITS;

    // Configuration registers
    logic              straight_mode_reg;
    logic [DIT_W-1:0]  dit_samples_reg;
    logic [STEP_W-1:0] tone_step_reg;
    logic              cfg_fire;

    // Keyer state
    keyer_phase_t      phase_reg;
    keyer_phase_t      phase_next;
    logic [TICKS_W-1:0] ticks_reg;
    logic [TICKS_W-1:0] ticks_next;
    logic [TICKS_W-1:0] ticks_load;
    logic [TICKS_W-1:0] ticks_sel;
    logic               tone_reg;
    logic               tone_next;
    logic               load;
    logic               done;
    logic [TICKS_W:0]   dah_raw;
    logic [TICKS_W-1:0] dah_len;
    logic [TICKS_W-1:0] dit_len;

    // Phase accumulator and sine ROM
    logic [ACC_W-1:0]           acc_reg;
    logic [TABLE_BITS-1:0]      rom_addr;
    logic signed [SAMPLE_W-1:0] sine_rom [TABLE_SIZE];
    logic signed [SAMPLE_W-1:0] rom_q_reg;

    // Pipeline
    logic                       keys_fire;
    logic                       s1_valid_reg;
    logic                       s1_tone_reg;
    logic                       s2_valid_reg;
    logic                       s2_tone_reg;
    logic signed [SAMPLE_W-1:0] s2_sample_reg;
    logic                       s2_free;
    logic                       s1_move;

    // Config port, always ready
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            straight_mode_reg <= STRAIGHT_MODE_RST;
            dit_samples_reg   <= DIT_SAMPLES_RST;
            tone_step_reg     <= TONE_STEP_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg.reg_index)
                CFG_STRAIGHT_MODE: straight_mode_reg <= cfg.data[0];
                CFG_DIT_SAMPLES:   dit_samples_reg   <= cfg.data[DIT_W-1:0];
                CFG_TONE_STEP:     tone_step_reg     <= cfg.data[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    // Element lengths; dah saturates at the counter's full scale
    assign dit_len = TICKS_W'(dit_samples_reg);
    assign dah_raw = {2'b00, dit_samples_reg} + {1'b0, dit_samples_reg, 1'b0};
    assign dah_len = dah_raw[TICKS_W] ? '1 : dah_raw[TICKS_W-1:0];
    assign done    = (ticks_reg == '0);

    // Keyer next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (straight_mode_reg)
        begin
            phase_next = (keys.dit_paddle || keys.dah_paddle) ? PH_DIT : PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_DIT:
                    if (done)
                        phase_next = keys.dah_paddle ? PH_SPACE_DAH : PH_SPACE;
                PH_DAH:
                    if (done)
                        phase_next = keys.dit_paddle ? PH_SPACE_DIT : PH_SPACE;
                PH_SPACE:
                    if (done)
                    begin
                        if (keys.dit_paddle)
                            phase_next = PH_DIT;
                        else if (keys.dah_paddle)
                            phase_next = PH_DAH;
                        else
                            phase_next = PH_IDLE;
                    end
                PH_SPACE_DAH:
                    if (done)
                        phase_next = PH_DAH;
                PH_SPACE_DIT:
                    if (done)
                        phase_next = PH_DIT;
                default:
                begin
                    // idle, and unreachable codes acting as idle
                    if (keys.dit_paddle)
                        phase_next = PH_DIT;
                    else if (keys.dah_paddle)
                        phase_next = PH_DAH;
                end
            endcase
        end
    end

    // Keyer outputs: tone and tick count follow the phase entered
    always_comb
    begin
        load       = !straight_mode_reg && (phase_next != phase_reg);
        ticks_load = dit_len;
        tone_next  = tone_reg;
        if (straight_mode_reg)
        begin
            tone_next = keys.dit_paddle || keys.dah_paddle;
        end
        else if (load)
        begin
            case (phase_next)
                PH_DIT:
                begin
                    ticks_load = dit_len;
                    tone_next  = 1'b1;
                end
                PH_DAH:
                begin
                    ticks_load = dah_len;
                    tone_next  = 1'b1;
                end
                PH_SPACE, PH_SPACE_DAH, PH_SPACE_DIT:
                begin
                    ticks_load = dit_len;
                    tone_next  = 1'b0;
                end
                default:
                begin
                    // entering idle keeps count and tone
                    ticks_load = ticks_reg;
                    tone_next  = tone_reg;
                end
            endcase
        end
        ticks_sel  = load ? ticks_load : ticks_reg;
        ticks_next = (ticks_sel != '0) ? ticks_sel - 1'b1 : ticks_sel;
    end

    // Handshake control
    assign s2_free    = !s2_valid_reg || audio.ready;
    assign s1_move    = s1_valid_reg && s2_free;
    assign keys.ready = !s1_valid_reg || s2_free;
    assign keys_fire  = keys.valid && keys.ready;

    // Keyer state and phase accumulator advance once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ticks_reg <= '0;
            tone_reg  <= 1'b0;
            acc_reg   <= '0;
        end
        else if (keys_fire)
        begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            tone_reg  <= tone_next;
            acc_reg   <= acc_reg + ACC_W'(tone_step_reg);
        end
    end

    // Sine ROM, built at elaboration
    for (genvar g = 0; g < TABLE_SIZE; g++)
    begin : g_rom
        localparam logic signed [SAMPLE_W-1:0] ENTRY =
            sine_entry(int'(g), TABLE_BITS);
        assign sine_rom[g] = ENTRY;
    end

    // ROM read with the phase before this tick's step
    assign rom_addr = acc_reg[ACC_W-1 -: TABLE_BITS];

    always_ff @(posedge clk)
    begin
        if (keys_fire)
        begin
            rom_q_reg   <= sine_rom[rom_addr];
            s1_tone_reg <= tone_next;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_sample_reg <= s1_tone_reg ? rom_q_reg : '0;
            s2_tone_reg   <= s1_tone_reg;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (keys_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                s2_valid_reg <= 1'b1;
            else if (audio.ready)
                s2_valid_reg <= 1'b0;
        end
    end

    assign audio.valid        = s2_valid_reg;
    assign audio.audio_sample = s2_sample_reg;
    assign audio.tone_on      = s2_tone_reg;

endmodule

`default_nettype wire

@@ hw/rtl/iktg_checker.sv @@
// Port-level checker for the keyer tone gate, bound to the top level.
`default_nettype none

module iktg_checker import iktg_pkg::*; (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic signed [SAMPLE_W-1:0] audio_sample,
    input wire logic                       tone_on
);

    // Gated tone: silence whenever the tone is off
    a_silent_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tone_on |-> audio_sample == '0)
        else $error("audio sample nonzero while tone is off");

    // Every taken tick yields a valid result behind the ROM read and output registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("no result two cycles after a paddle transfer");

    // An empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output stage is empty");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(audio_sample) && $stable(tone_on))
        else $error("stalled result changed");

endmodule

bind iambic_keyer_tone_gate_top iktg_checker u_iktg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (keys.valid),
    .in_ready     (keys.ready),
    .out_valid    (audio.valid),
    .out_ready    (audio.ready),
    .audio_sample (audio.audio_sample),
    .tone_on      (audio.tone_on)
);

`default_nettype wire

@@ bench/tb_iambic_keyer_tone_gate_top.sv @@
// Self-checking testbench for the iambic keyer tone gate: directed table, random keying, checks.
module tb_iambic_keyer_tone_gate_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iktg_pkg::*;

    localparam real         PI_R         = 3.14159265358979323846;
    localparam int          FULL_SCALE   = 32767;
    localparam int unsigned DIT_AT_RST   = 900;
    localparam int unsigned STEP_AT_RST  = 782937;
    localparam int unsigned STEP_MAX     = 23'h7FFFFF;
    localparam int unsigned DAH_SAT_DIT  = 21846;   // three dits just past 16 bits
    localparam int          N_PHASES     = 16;
    localparam int          PHASE_ITEMS  = 78;
    localparam int          HOLD_PHASE   = 6;
    localparam int          PAUSE_PHASE  = 9;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          LONG_TICKS   = 40;
    localparam int          N_ROWS       = 29;

    // One audio transfer as the checker sees it
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       tone;
    } audio_exp_t;

    // Directed row: either a register write or a paddle tick
    typedef struct {
        bit                    is_cfg;
        cfg_reg_t              rsel;
        logic [CFG_DATA_W-1:0] value;
        bit                    dit;
        bit                    dah;
        bit                    silent;   // result known by eye: tone off, sample zero
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    iktg_cfg_if   cfg_ch ();
    iktg_key_if   key_ch ();
    iktg_audio_if aud_ch ();

    iambic_keyer_tone_gate_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .keys  (key_ch),
        .audio (aud_ch)
    );

    // Keyer model state and its copy of the registers
    keyer_phase_t         kp;
    logic [TICKS_W-1:0]   ticks_rem;
    logic                 tone_gate;
    logic [23:0]          phase_acc;
    logic                 cfg_straight;
    logic [DIT_W-1:0]     cfg_dit;
    logic [STEP_W-1:0]    cfg_step;
    logic signed [15:0]   sine_lut [0:255];

    audio_exp_t audio_due [$];
    int         n_bad = 0;
    int         tx_gap_max;
    int         rx_stall_max;
    bit         hold_req;
    dir_row_t   dir_plan [N_ROWS];

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Keyer element start: tone on, count loaded
    task automatic start_mark(input keyer_phase_t ph, input logic [TICKS_W-1:0] len);
        kp        = ph;
        ticks_rem = len;
        tone_gate = 1'b1;
    endtask

    // Keyer element end: one-dit space, opposite paddle queues the other element
    task automatic end_mark(input bit other, input keyer_phase_t queued);
        kp        = other ? queued : PH_SPACE;
        ticks_rem = {1'b0, cfg_dit};
        tone_gate = 1'b0;
    endtask

    // One sample tick of the keyer and tone generator
    task automatic keyer_tick(input bit dit, input bit dah, output audio_exp_t res);
        bit                 done;
        logic [16:0]        dah_raw;
        logic [TICKS_W-1:0] dah_ticks;
        logic [TICKS_W-1:0] dit_ticks;
        done      = (ticks_rem == '0);
        dit_ticks = {1'b0, cfg_dit};
        dah_raw   = {2'b00, cfg_dit} * 17'd3;
        dah_ticks = dah_raw[16] ? 16'hFFFF : dah_raw[15:0];
        if (cfg_straight)
        begin
            if (dit || dah)
            begin
                kp        = PH_DIT;
                tone_gate = 1'b1;
            end
            else
            begin
                kp        = PH_IDLE;
                tone_gate = 1'b0;
            end
        end
        else
        begin
            case (kp)
                PH_DIT:
                    if (done)
                        end_mark(dah, PH_SPACE_DAH);
                PH_DAH:
                    if (done)
                        end_mark(dit, PH_SPACE_DIT);
                PH_SPACE:
                    if (done)
                    begin
                        if (dit)
                            start_mark(PH_DIT, dit_ticks);
                        else if (dah)
                            start_mark(PH_DAH, dah_ticks);
                        else
                            kp = PH_IDLE;
                    end
                PH_SPACE_DAH:
                    if (done)
                        start_mark(PH_DAH, dah_ticks);
                PH_SPACE_DIT:
                    if (done)
                        start_mark(PH_DIT, dit_ticks);
                default:
                    if (dit)
                        start_mark(PH_DIT, dit_ticks);
                    else if (dah)
                        start_mark(PH_DAH, dah_ticks);
            endcase
        end
        res.tone   = tone_gate;
        res.sample = tone_gate ? sine_lut[phase_acc[23:16]] : '0;
        phase_acc  = phase_acc + {1'b0, cfg_step};
        if (ticks_rem != '0)
            ticks_rem = ticks_rem - 1'b1;
    endtask

    // Paddle transfer after a random gap; the expectation is queued at acceptance
    task automatic send_tick(input bit dit, input bit dah, input bit silent);
        int unsigned gap;
        audio_exp_t  res;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0)
        begin
            key_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        key_ch.valid      <= 1'b1;
        key_ch.dit_paddle <= dit;
        key_ch.dah_paddle <= dah;
        do
            @(posedge clk);
        while (key_ch.ready !== 1'b1);
        keyer_tick(dit, dah, res);
        if (silent)
        begin
            res.sample = '0;
            res.tone   = 1'b0;
        end
        audio_due.push_back(res);
        @(negedge clk);
    endtask

    // A held paddle pattern, or random levels when noisy
    task automatic send_run(input bit dit, input bit dah, input bit noisy, input int len);
        int k;
        for (k = 0; k < len; k++)
        begin
            if (noisy)
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
            else
                send_tick(dit, dah, 1'b0);
        end
    endtask

    // Stop offering ticks and wait for every expected result
    task automatic wait_drained();
        key_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (audio_due.size() != 0);
    endtask

    // Register write; valid stays up until the caller lowers it
    task automatic cfg_write(input cfg_reg_t rsel, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= rsel;
        cfg_ch.data      <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (rsel)
            CFG_STRAIGHT_MODE: cfg_straight = value[0];
            CFG_DIT_SAMPLES:   cfg_dit      = value[DIT_W-1:0];
            CFG_TONE_STEP:     cfg_step     = value[STEP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Audio side: random stalls, one long hold on request, in-order check
    initial
    begin : audio_rx
        int unsigned stall;
        audio_exp_t  want;
        bit          held;
        aud_ch.ready = 1'b0;
        held         = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            else
            begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall != 0)
            begin
                aud_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            aud_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (aud_ch.valid !== 1'b1);
            if (audio_due.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: audio transfer with nothing expected: sample %0d tone %b",
                             $realtime, aud_ch.audio_sample, aud_ch.tone_on);
            end
            else
            begin
                want = audio_due.pop_front();
                if (aud_ch.audio_sample !== want.sample || aud_ch.tone_on !== want.tone)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: expected sample %0d tone %b, got sample %0d tone %b",
                                 $realtime, want.sample, want.tone,
                                 aud_ch.audio_sample, aud_ch.tone_on);
                end
            end
            @(negedge clk);
        end
    end

    // Main sequence: reset, directed table, random phases, saturated dah
    initial
    begin : stimulus
        int          i;
        int          p;
        int          n;
        int          r;
        int          len;
        int          mag;
        int unsigned combo;
        int unsigned j;
        bit          neg;
        bit          in_cfg;
        bit          paused;
        logic [CFG_DATA_W-1:0] dit_val;
        logic [CFG_DATA_W-1:0] step_val;

        rst_n             = 1'b0;
        key_ch.valid      = 1'b0;
        key_ch.dit_paddle = 1'b0;
        key_ch.dah_paddle = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.reg_index  = '0;
        cfg_ch.data       = '0;
        hold_req          = 1'b0;
        tx_gap_max        = 7;
        rx_stall_max      = 7;

        // Sine table, quarter-wave symmetric, truncated toward zero
        for (i = 0; i < 256; i++)
        begin
            j   = i;
            neg = 1'b0;
            if (j >= 128)
            begin
                neg = 1'b1;
                j   = j - 128;
            end
            if (j > 64)
                j = 128 - j;
            if (j == 0)
                mag = 0;
            else if (j == 64)
                mag = FULL_SCALE;
            else
                mag = $rtoi(32767.0 * $sin(PI_R * j / 128.0));
            sine_lut[i] = 16'(neg ? -mag : mag);
        end

        // Model at reset
        kp           = PH_IDLE;
        ticks_rem    = '0;
        tone_gate    = 1'b0;
        phase_acc    = '0;
        cfg_straight = 1'b0;
        cfg_dit      = DIT_W'(DIT_AT_RST);
        cfg_step     = STEP_W'(STEP_AT_RST);

        dir_plan = '{
            // reset settings: idle, start of a default dit, straight-key switch mid-dit
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b1},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b1, 1'b0, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b0},
            '{1'b1, CFG_STRAIGHT_MODE, 23'd1, 1'b0, 1'b0, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b1},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b1, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b1, 1'b1, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b1},
            // one-tick dit, full-scale step so the phase wraps
            '{1'b1, CFG_DIT_SAMPLES,   23'd1, 1'b0, 1'b0, 1'b0},
            '{1'b1, CFG_TONE_STEP,     23'h7FFFFF, 1'b0, 1'b0, 1'b0},
            '{1'b1, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b0},
            // dit, queued dah, dah with queued dit, dit, plain space, dah, back to idle
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b1, 1'b1, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b1, 1'b1},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b1, 1'b0, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b1, 1'b0, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b1, 1'b0, 1'b1},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b1},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b1, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b1},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b1},
            // zero dit length, zero step
            '{1'b1, CFG_DIT_SAMPLES,   23'd0, 1'b0, 1'b0, 1'b0},
            '{1'b1, CFG_TONE_STEP,     23'd0, 1'b0, 1'b0, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b1, 1'b0, 1'b0},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b1},
            '{1'b0, CFG_STRAIGHT_MODE, 23'd0, 1'b0, 1'b0, 1'b1}
        };

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        in_cfg = 1'b0;
        for (i = 0; i < N_ROWS; i++)
        begin
            if (dir_plan[i].is_cfg)
            begin
                if (!in_cfg)
                    wait_drained();
                cfg_write(dir_plan[i].rsel, dir_plan[i].value);
                in_cfg = 1'b1;
            end
            else
            begin
                if (in_cfg)
                begin
                    cfg_ch.valid <= 1'b0;
                    in_cfg = 1'b0;
                end
                send_tick(dir_plan[i].dit, dir_plan[i].dah, dir_plan[i].silent);
            end
        end

        // Random phases, each with its own settings
        for (p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:       dit_val = 23'd0;
                1:       dit_val = 23'd1;
                2:       dit_val = 23'd2;
                default: dit_val = CFG_DATA_W'($urandom_range(0, 12));
            endcase
            case (p)
                0:       step_val = 23'd0;
                1:       step_val = CFG_DATA_W'(STEP_MAX);
                default: step_val = CFG_DATA_W'($urandom_range(0, STEP_MAX));
            endcase
            wait_drained();
            cfg_write(CFG_STRAIGHT_MODE, (p % 4 == 3) ? 23'd1 : 23'd0);
            cfg_write(CFG_DIT_SAMPLES, dit_val);
            cfg_write(CFG_TONE_STEP, step_val);
            cfg_ch.valid <= 1'b0;
            tx_gap_max   = (p % 5 == 2) ? 0 : 7;
            rx_stall_max = (p % 5 == 2 || p % 7 == 4) ? 0 : 7;
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            paused = 1'b0;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                // sender waits out every result once, mid-phase
                if (p == PAUSE_PHASE && !paused && n >= PHASE_ITEMS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 9);
                if (r <= 6)
                begin
                    // held paddles long enough to finish and queue elements
                    combo = $urandom_range(1, 3);
                    len   = $urandom_range(1, 3 * cfg_dit + 4);
                    if (len > PHASE_ITEMS - n)
                        len = PHASE_ITEMS - n;
                    send_run(combo[0], combo[1], 1'b0, len);
                end
                else if (r <= 8)
                begin
                    len = $urandom_range(1, 2 * cfg_dit + 3);
                    if (len > PHASE_ITEMS - n)
                        len = PHASE_ITEMS - n;
                    send_run(1'b0, 1'b0, 1'b0, len);
                end
                else
                begin
                    len = $urandom_range(1, 4);
                    if (len > PHASE_ITEMS - n)
                        len = PHASE_ITEMS - n;
                    send_run(1'b0, 1'b0, 1'b1, len);
                end
                n = n + len;
            end
        end

        // Let the keyer fall idle, then a dah whose triple length overflows 16 bits:
        // the count saturates, so the tone holds far past a wrapped length
        while (kp != PH_IDLE)
            send_tick(1'b0, 1'b0, 1'b0);
        wait_drained();
        cfg_write(CFG_STRAIGHT_MODE, 23'd0);
        cfg_write(CFG_DIT_SAMPLES, CFG_DATA_W'(DAH_SAT_DIT));
        cfg_write(CFG_TONE_STEP, CFG_DATA_W'($urandom_range(0, STEP_MAX)));
        cfg_ch.valid <= 1'b0;
        tx_gap_max   = 0;
        rx_stall_max = 0;
        send_tick(1'b0, 1'b1, 1'b0);
        send_run(1'b0, 1'b0, 1'b1, LONG_TICKS);

        // Drain and settle past the pipeline depth
        wait_drained();
        repeat (8) @(negedge clk);
        if (n_bad == 0 && audio_due.size() == 0)
            $display("tb_iambic_keyer_tone_gate_top: PASS");
        else
            $display("tb_iambic_keyer_tone_gate_top: FAIL");
        $finish;
    end

    // Run limit
    initial
    begin : watchdog
        #5_000_000;
        $display("tb_iambic_keyer_tone_gate_top: FAIL");
        $finish;
    end

endmodule
